/* hw/rtl/ocsa_pkg.sv */
// Shared types and constants of the overlap-checked slot allocator.
`default_nettype none

package ocsa_pkg;

    // Fixed field widths.
    localparam int RES_ID_W  = 6;
    localparam int STATUS_W  = 3;
    localparam int HALF_W    = 15;
    localparam int CFG_IDX_W = 1;

    // Operation codes on the input channel.
    localparam logic FUNC_ADD    = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_Y = 1'b1;

    // Reset value of both half sizes (0.5 in unsigned Q3.12).
    localparam logic [HALF_W-1:0] HALF_RESET = 15'd2048;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OVERLAP = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REMOVED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_INVALID = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_run;
        logic rem_read;
        logic rem_exec;
        logic alloc;
        logic out_load;
    } ocsa_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_hit;
        logic scan_done;
        logic out_free;
    } ocsa_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/ocsa_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module ocsa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hw/rtl/ocsa_ctrl.sv */
// Controller state machine of the slot allocator.
`default_nettype none

module ocsa_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_func,
    input  wire ocsa_pkg::ocsa_sts_t sts,
    output ocsa_pkg::ocsa_cmd_t    cmd
);

    import ocsa_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN     = 3'd1;
    localparam logic [2:0] S_ALLOC    = 3'd2;
    localparam logic [2:0] S_REM_RD   = 3'd3;
    localparam logic [2:0] S_REM_EXEC = 3'd4;
    localparam logic [2:0] S_FIN      = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (s_func == FUNC_REMOVE) begin
                        state_next = S_REM_RD;
                    end else begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                cmd.scan_run = 1'b1;
                if (sts.scan_hit) begin
                    state_next = S_FIN;
                end else if (sts.scan_done) begin
                    state_next = S_ALLOC;
                end
            end
            S_ALLOC: begin
                cmd.alloc  = 1'b1;
                state_next = S_FIN;
            end
            S_REM_RD: begin
                cmd.rem_read = 1'b1;
                state_next   = S_REM_EXEC;
            end
            S_REM_EXEC: begin
                cmd.rem_exec = 1'b1;
                state_next   = S_FIN;
            end
            S_FIN: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/ocsa_dp.sv */
// Datapath of the slot allocator: slot table, free stack, scan pipeline and result register.
`default_nettype none

module ocsa_dp #(
    parameter int MAX_SLOTS  = 64,
    parameter int COORD_BITS = 16
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire ocsa_pkg::ocsa_cmd_t                    cmd,
    output ocsa_pkg::ocsa_sts_t                         sts,
    input  wire logic signed [COORD_BITS-1:0]           s_pos_x,
    input  wire logic signed [COORD_BITS-1:0]           s_pos_y,
    input  wire logic signed [COORD_BITS-1:0]           s_pos_z,
    input  wire logic [ocsa_pkg::RES_ID_W-1:0]          s_slot_id,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [ocsa_pkg::CFG_IDX_W-1:0]         cfg_addr,
    input  wire logic [ocsa_pkg::HALF_W-1:0]            cfg_wdata,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic [ocsa_pkg::STATUS_W-1:0]               m_status,
    output logic [ocsa_pkg::RES_ID_W-1:0]               m_result_id,
    output logic [ocsa_pkg::RES_ID_W-1:0]               m_hit_id
);

    import ocsa_pkg::*;

    localparam int ID_W     = $clog2(MAX_SLOTS);
    localparam int CNT_W    = $clog2(MAX_SLOTS + 1);
    localparam int CMP_W    = (CNT_W > RES_ID_W) ? CNT_W : RES_ID_W;
    localparam int WORD_W   = 3 * COORD_BITS + 1;
    localparam int DIFF_W   = COORD_BITS + 1;
    localparam int BOX_W    = (DIFF_W > HALF_W + 1) ? DIFF_W : HALF_W + 1;
    localparam int PROD_W   = 2 * COORD_BITS;
    localparam int SUM_W    = PROD_W + 2;

    // Captured item and configuration.
    logic signed [COORD_BITS-1:0] px_reg, py_reg, pz_reg;
    logic [RES_ID_W-1:0]          sid_reg;
    logic [HALF_W-1:0]            half_x_reg, half_y_reg;

    // Table bookkeeping.
    logic [CNT_W-1:0] used_count_reg, free_top_reg, scan_idx_reg;

    // Scan pipeline.
    logic                     rd_v_reg, a_v_reg, b_v_reg;
    logic [ID_W-1:0]          rd_idx_reg, a_idx_reg, b_idx_reg;
    logic                     a_ovx_reg, a_ovy_reg, a_act_reg, b_hit_reg;
    logic signed [PROD_W-1:0] a_px_reg, a_py_reg, a_pz_reg;

    // Result held until the output register is free.
    logic [STATUS_W-1:0] res_status_reg;
    logic [RES_ID_W-1:0] res_id_reg, res_hit_reg;

    // Output register.
    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [RES_ID_W-1:0] m_result_id_reg, m_hit_id_reg;

    // Memory ports.
    logic              slot_we;
    logic [ID_W-1:0]   slot_waddr, slot_raddr;
    logic [WORD_W-1:0] slot_wdata, slot_q;
    logic              stack_we;
    logic [ID_W-1:0]   stack_raddr;
    logic [ID_W-1:0]   stack_q;

    logic                     q_act;
    logic signed [COORD_BITS-1:0] q_x, q_y, q_z;
    logic [ID_W-1:0]          sid_addr;
    logic                     issue_pending;
    logic                     rem_ok;
    logic                     alloc_from_stack, alloc_fresh;
    logic [ID_W-1:0]          new_id;

    logic signed [DIFF_W-1:0] dx, dy;
    logic [DIFF_W-1:0]        abs_x, abs_y;
    logic                     ovx, ovy;
    logic signed [PROD_W-1:0] prod_x, prod_y, prod_z;
    logic signed [SUM_W-1:0]  dot_sum;
    logic                     dot_pos;

    assign sid_addr = ID_W'(sid_reg);
    assign q_act    = slot_q[3*COORD_BITS];
    assign q_x      = slot_q[2*COORD_BITS +: COORD_BITS];
    assign q_y      = slot_q[COORD_BITS +: COORD_BITS];
    assign q_z      = slot_q[0 +: COORD_BITS];

    assign issue_pending = scan_idx_reg < used_count_reg;

    // Remove check: id in use, inside the table and the slot still active.
    assign rem_ok = (CMP_W'(sid_reg) < CMP_W'(used_count_reg)) &&
                    (CMP_W'(sid_reg) < CMP_W'(MAX_SLOTS)) &&
                    q_act && (free_top_reg < CNT_W'(MAX_SLOTS));

    // Allocation: last freed id first, else the next fresh one.
    assign alloc_from_stack = free_top_reg != '0;
    assign alloc_fresh      = !alloc_from_stack && (used_count_reg < CNT_W'(MAX_SLOTS));
    assign new_id           = alloc_from_stack ? stack_q : used_count_reg[ID_W-1:0];

    // Memory address and data selection.
    always_comb begin
        slot_raddr = cmd.rem_read ? sid_addr : scan_idx_reg[ID_W-1:0];
        slot_we    = 1'b0;
        slot_waddr = sid_addr;
        slot_wdata = '0;
        stack_we   = 1'b0;
        if (cmd.rem_exec && rem_ok) begin
            slot_we  = 1'b1;
            stack_we = 1'b1;
        end
        if (cmd.alloc && (alloc_from_stack || alloc_fresh)) begin
            slot_we    = 1'b1;
            slot_waddr = new_id;
            slot_wdata = {1'b1, px_reg, py_reg, pz_reg};
        end
    end

    // The top of the free stack is read continuously.
    assign stack_raddr = ID_W'(free_top_reg - CNT_W'(1));

    ocsa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_SLOTS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_q)
    );

    ocsa_ram #(
        .WIDTH (ID_W),
        .DEPTH (MAX_SLOTS)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (stack_we),
        .waddr (free_top_reg[ID_W-1:0]),
        .wdata (sid_addr),
        .raddr (stack_raddr),
        .rdata (stack_q)
    );

    // Stage A logic: box distance tests and the three products.
    always_comb begin
        dx     = DIFF_W'(px_reg) - DIFF_W'(q_x);
        dy     = DIFF_W'(py_reg) - DIFF_W'(q_y);
        abs_x  = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
        abs_y  = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
        ovx    = BOX_W'(abs_x) < BOX_W'({half_x_reg, 1'b0});
        ovy    = BOX_W'(abs_y) < BOX_W'({half_y_reg, 1'b0});
        prod_x = px_reg * q_x;
        prod_y = py_reg * q_y;
        prod_z = pz_reg * q_z;
    end

    // Stage B logic: exact sign of the dot product.
    always_comb begin
        dot_sum = SUM_W'(a_px_reg) + SUM_W'(a_py_reg) + SUM_W'(a_pz_reg);
        dot_pos = !dot_sum[SUM_W-1] && (dot_sum != '0);
    end

    assign sts.scan_hit  = b_v_reg && b_hit_reg;
    assign sts.scan_done = !issue_pending && !rd_v_reg && !a_v_reg && !(b_v_reg && b_hit_reg);
    assign sts.out_free  = !m_valid_reg || m_ready;

    // Item capture and scan pipeline payload.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            px_reg  <= s_pos_x;
            py_reg  <= s_pos_y;
            pz_reg  <= s_pos_z;
            sid_reg <= s_slot_id;
        end
        rd_idx_reg <= scan_idx_reg[ID_W-1:0];
        a_idx_reg  <= rd_idx_reg;
        a_ovx_reg  <= ovx;
        a_ovy_reg  <= ovy;
        a_act_reg  <= q_act;
        a_px_reg   <= prod_x;
        a_py_reg   <= prod_y;
        a_pz_reg   <= prod_z;
        b_idx_reg  <= a_idx_reg;
        b_hit_reg  <= a_ovx_reg && a_ovy_reg && a_act_reg && dot_pos;
    end

    // Control registers: configuration, counters and pipeline valids.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_x_reg     <= HALF_RESET;
            half_y_reg     <= HALF_RESET;
            used_count_reg <= '0;
            free_top_reg   <= '0;
            scan_idx_reg   <= '0;
            rd_v_reg       <= 1'b0;
            a_v_reg        <= 1'b0;
            b_v_reg        <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_HALF_X: half_x_reg <= cfg_wdata;
                    CFG_HALF_Y: half_y_reg <= cfg_wdata;
                    default:    half_x_reg <= half_x_reg;
                endcase
            end
            if (cmd.scan_start) begin
                scan_idx_reg <= '0;
                rd_v_reg     <= 1'b0;
                a_v_reg      <= 1'b0;
                b_v_reg      <= 1'b0;
            end else begin
                rd_v_reg <= cmd.scan_run && issue_pending;
                a_v_reg  <= rd_v_reg;
                b_v_reg  <= a_v_reg;
                if (cmd.scan_run && issue_pending) begin
                    scan_idx_reg <= scan_idx_reg + CNT_W'(1);
                end
            end
            if (cmd.rem_exec && rem_ok) begin
                free_top_reg <= free_top_reg + CNT_W'(1);
            end
            if (cmd.alloc) begin
                if (alloc_from_stack) begin
                    free_top_reg <= free_top_reg - CNT_W'(1);
                end else if (alloc_fresh) begin
                    used_count_reg <= used_count_reg + CNT_W'(1);
                end
            end
        end
    end

    // Result of the current transaction.
    always_ff @(posedge aclk) begin
        if (cmd.rem_exec) begin
            if (rem_ok) begin
                res_status_reg <= ST_REMOVED;
                res_id_reg     <= sid_reg;
            end else begin
                res_status_reg <= ST_INVALID;
                res_id_reg     <= '0;
            end
            res_hit_reg <= '0;
        end
        if (cmd.alloc) begin
            if (alloc_from_stack || alloc_fresh) begin
                res_status_reg <= ST_ADDED;
                res_id_reg     <= RES_ID_W'(new_id);
            end else begin
                res_status_reg <= ST_FULL;
                res_id_reg     <= '0;
            end
            res_hit_reg <= '0;
        end
        if (cmd.scan_run && sts.scan_hit) begin
            res_status_reg <= ST_OVERLAP;
            res_id_reg     <= '0;
            res_hit_reg    <= RES_ID_W'(b_idx_reg);
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_status_reg    <= res_status_reg;
            m_result_id_reg <= res_id_reg;
            m_hit_id_reg    <= res_hit_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_result_id = m_result_id_reg;
    assign m_hit_id    = m_hit_id_reg;

endmodule

`default_nettype wire

/* hw/rtl/overlap_checked_slot_allocator_core.sv */
// Top level of the overlap-checked slot allocator.
//
// The block keeps a table of MAX_SLOTS positions (signed Q4.12 per axis) with a
// free stack of released ids. An add (func 0) scans the used slots in index order
// and rejects the position at the first active slot whose x/y box strictly
// overlaps the new one and whose dot product with it is positive; otherwise it
// takes the most recently freed id, or the next fresh id, and reports it. A
// remove (func 1) releases an active id in range and reports it, and flags any
// other id as invalid. During an add the slot RAM read port delivers one slot per
// cycle into a three-stage compare and dot-product pipeline, and the scan ends at
// the first hit or once every used slot has passed through it. A finished result
// waits until the output register is free. One transaction is in work at a time,
// and a new one is taken while the previous result still waits on the output.
// The half sizes are to be written through the configuration port only while the
// block is idle; the block itself does not enforce this.
`default_nettype none

module overlap_checked_slot_allocator_core #(
    parameter int MAX_SLOTS  = 64,
    parameter int COORD_BITS = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_func,
    input  wire logic signed [COORD_BITS-1:0]     s_pos_x,
    input  wire logic signed [COORD_BITS-1:0]     s_pos_y,
    input  wire logic signed [COORD_BITS-1:0]     s_pos_z,
    input  wire logic [ocsa_pkg::RES_ID_W-1:0]    s_slot_id,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [ocsa_pkg::STATUS_W-1:0]         m_status,
    output logic [ocsa_pkg::RES_ID_W-1:0]         m_result_id,
    output logic [ocsa_pkg::RES_ID_W-1:0]         m_hit_id,
    input  wire logic                             cfg_wr_en,
    input  wire logic [ocsa_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  wire logic [ocsa_pkg::HALF_W-1:0]      cfg_wdata
);

    import ocsa_pkg::*;

    ocsa_cmd_t cmd;
    ocsa_sts_t sts;

    // Sequencing of add and remove transactions.
    ocsa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_func  (s_func),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Table storage, scan pipeline and result register.
    ocsa_dp #(
        .MAX_SLOTS  (MAX_SLOTS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .s_pos_x     (s_pos_x),
        .s_pos_y     (s_pos_y),
        .s_pos_z     (s_pos_z),
        .s_slot_id   (s_slot_id),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_result_id (m_result_id),
        .m_hit_id    (m_hit_id)
    );

endmodule

`default_nettype wire

/* tb/sv/overlap_checked_slot_allocator_core_tb.sv */
// Self-checking testbench for the overlap-checked slot allocator core.
`default_nettype none

module overlap_checked_slot_allocator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ocsa_pkg::*;

    localparam int MAX_SLOTS       = 64;
    localparam int COORD_BITS      = 16;
    localparam int N_DIRECTED      = 21;
    localparam int N_PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 220;
    localparam int PRESSURE_PHASE  = 2;
    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = 80;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int MAX_PRINTED     = 100;

    // Half sizes per phase; a negative entry means a random value.
    localparam int PHASE_HX [N_PHASES] = '{2048, 0, 32767, 32767, 0, 1, -1, 2048};
    localparam int PHASE_HY [N_PHASES] = '{2048, 0, 32767, 0, 32767, 1, -1, 2048};
    localparam int PHASE_ADD_PCT [N_PHASES] = '{60, 85, 50, 60, 60, 65, 55, 35};

    // One request on the input channel.
    typedef struct packed {
        logic                         func;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
        logic [RES_ID_W-1:0]          id;
    } alloc_req_t;

    // One response on the result channel.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [RES_ID_W-1:0] result_id;
        logic [RES_ID_W-1:0] hit_id;
    } alloc_resp_t;

    // Directed row: a request, and a fixed response where typed is set.
    typedef struct packed {
        alloc_req_t  req;
        logic        typed;
        alloc_resp_t resp;
    } dir_row_t;

    localparam alloc_resp_t NO_RESP = '0;

    localparam dir_row_t DIR_ROWS [N_DIRECTED] = '{
        // Remove on an empty table.
        '{'{FUNC_REMOVE, 16'sd0, 16'sd0, 16'sd0, 6'd0}, 1'b1, '{ST_INVALID, 6'd0, 6'd0}},
        '{'{FUNC_ADD, 16'sd0, 16'sd0, 16'sd0, 6'd0}, 1'b1, '{ST_ADDED, 6'd0, 6'd0}},
        // Largest coordinates, then a close neighbor that must be rejected.
        '{'{FUNC_ADD, 16'h7FFF, 16'h7FFF, 16'h7FFF, 6'd0}, 1'b1, '{ST_ADDED, 6'd1, 6'd0}},
        '{'{FUNC_ADD, 16'sd32667, 16'h7FFF, 16'h7FFF, 6'd0}, 1'b1,
          '{ST_OVERLAP, 6'd0, 6'd1}},
        // Smallest coordinates, twice.
        '{'{FUNC_ADD, 16'h8000, 16'h8000, 16'h8000, 6'd63}, 1'b1, '{ST_ADDED, 6'd2, 6'd0}},
        '{'{FUNC_ADD, 16'h8000, 16'h8000, 16'h8000, 6'd0}, 1'b1,
          '{ST_OVERLAP, 6'd0, 6'd2}},
        // Box overlaps slot 0 but the dot product is zero.
        '{'{FUNC_ADD, 16'sd0, 16'sd0, 16'sd100, 6'd0}, 1'b0, NO_RESP},
        // Box overlaps slot 0 and the dot product is again zero.
        '{'{FUNC_ADD, 16'sd100, 16'sd100, -16'sd10000, 6'd0}, 1'b0, NO_RESP},
        '{'{FUNC_ADD, 16'sd8192, 16'sd8192, 16'sd8192, 6'd0}, 1'b0, NO_RESP},
        // Exactly on the box edge, then one step inside.
        '{'{FUNC_ADD, 16'sd12288, 16'sd8192, 16'sd8192, 6'd0}, 1'b0, NO_RESP},
        '{'{FUNC_ADD, 16'sd12287, 16'sd8192, 16'sd8192, 6'd0}, 1'b0, NO_RESP},
        // Remove beyond the used range.
        '{'{FUNC_REMOVE, 16'sd0, 16'sd0, 16'sd0, 6'd63}, 1'b1, '{ST_INVALID, 6'd0, 6'd0}},
        '{'{FUNC_REMOVE, 16'h7FFF, 16'h8000, 16'h7FFF, 6'd4}, 1'b0, NO_RESP},
        // Double remove of the same slot.
        '{'{FUNC_REMOVE, 16'sd0, 16'sd0, 16'sd0, 6'd4}, 1'b1, '{ST_INVALID, 6'd0, 6'd0}},
        '{'{FUNC_REMOVE, 16'sd0, 16'sd0, 16'sd0, 6'd3}, 1'b0, NO_RESP},
        // Freed ids come back last freed first, then fresh ids follow.
        '{'{FUNC_ADD, 16'sd1000, -16'sd20000, 16'sd5, 6'd0}, 1'b0, NO_RESP},
        '{'{FUNC_ADD, -16'sd20000, 16'sd20000, 16'sd0, 6'd63}, 1'b0, NO_RESP},
        '{'{FUNC_ADD, 16'sd20000, -16'sd20000, 16'sd0, 6'd0}, 1'b0, NO_RESP},
        // A removed slot holds zero and no longer blocks its old place.
        '{'{FUNC_REMOVE, 16'sd0, 16'sd0, 16'sd0, 6'd5}, 1'b0, NO_RESP},
        '{'{FUNC_ADD, 16'sd8192, 16'sd8192, 16'sd8192, 6'd0}, 1'b0, NO_RESP},
        '{'{FUNC_REMOVE, 16'sd0, 16'sd0, 16'sd0, 6'd0}, 1'b0, NO_RESP}
    };

    logic                         aclk;
    logic                         aresetn;
    logic                         s_valid;
    logic                         s_ready;
    logic                         s_func;
    logic signed [COORD_BITS-1:0] s_pos_x;
    logic signed [COORD_BITS-1:0] s_pos_y;
    logic signed [COORD_BITS-1:0] s_pos_z;
    logic [RES_ID_W-1:0]          s_slot_id;
    logic                         m_valid;
    logic                         m_ready;
    logic [STATUS_W-1:0]          m_status;
    logic [RES_ID_W-1:0]          m_result_id;
    logic [RES_ID_W-1:0]          m_hit_id;
    logic                         cfg_wr_en;
    logic [CFG_IDX_W-1:0]         cfg_addr;
    logic [HALF_W-1:0]            cfg_wdata;

    // Shadow copy of the slot table, free stack and half sizes.
    int tbl_x [MAX_SLOTS];
    int tbl_y [MAX_SLOTS];
    int tbl_z [MAX_SLOTS];
    bit tbl_active [MAX_SLOTS];
    int freed_ids [MAX_SLOTS];
    int n_used;
    int n_freed;
    int half_x;
    int half_y;

    alloc_resp_t expected_q [$];
    int          err_count   = 0;
    int          idle_cycles = 0;
    bit          rst_done     = 1'b0;
    bit          tx_idle_on   = 1'b1;
    bit          rx_idle_on   = 1'b1;
    bit          hold_off_req = 1'b0;

    overlap_checked_slot_allocator_core #(
        .MAX_SLOTS  (MAX_SLOTS),
        .COORD_BITS (COORD_BITS)
    ) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_pos_x     (s_pos_x),
        .s_pos_y     (s_pos_y),
        .s_pos_z     (s_pos_z),
        .s_slot_id   (s_slot_id),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_result_id (m_result_id),
        .m_hit_id    (m_hit_id),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Clear the shadow table to its post-reset state.
    function automatic void clear_table();
        for (int i = 0; i < MAX_SLOTS; i++) begin
            tbl_x[i] = 0;
            tbl_y[i] = 0;
            tbl_z[i] = 0;
            tbl_active[i] = 1'b0;
            freed_ids[i] = 0;
        end
        n_used = 0;
        n_freed = 0;
        half_x = int'(HALF_RESET);
        half_y = int'(HALF_RESET);
    endfunction

    // Apply one request to the shadow table and return the response it must give.
    function automatic alloc_resp_t apply_request(alloc_req_t req);
        alloc_resp_t r;
        int px, py, pz, wx, wy, dx, dy, id;
        longint dot;
        bit hit;
        r = '0;
        hit = 1'b0;
        if (req.func == FUNC_REMOVE) begin
            id = int'(req.id);
            if (id >= n_used || !tbl_active[id] || n_freed >= MAX_SLOTS) begin
                r.status = ST_INVALID;
            end else begin
                tbl_x[id] = 0;
                tbl_y[id] = 0;
                tbl_z[id] = 0;
                tbl_active[id] = 1'b0;
                freed_ids[n_freed] = id;
                n_freed++;
                r.status = ST_REMOVED;
                r.result_id = RES_ID_W'(id);
            end
        end else begin
            px = $signed(req.x);
            py = $signed(req.y);
            pz = $signed(req.z);
            wx = 2 * half_x;
            wy = 2 * half_y;
            // Scan used slots in order; the first strict overlap on the same side wins.
            for (int i = 0; i < n_used && !hit; i++) begin
                dx = px - tbl_x[i];
                dy = py - tbl_y[i];
                if (dx < 0) dx = -dx;
                if (dy < 0) dy = -dy;
                dot = longint'(px) * tbl_x[i] + longint'(py) * tbl_y[i]
                    + longint'(pz) * tbl_z[i];
                if (dx < wx && dy < wy && dot > 0) begin
                    hit = 1'b1;
                    r.status = ST_OVERLAP;
                    r.hit_id = RES_ID_W'(i);
                end
            end
            if (!hit) begin
                if (n_freed > 0) begin
                    n_freed--;
                    id = freed_ids[n_freed];
                end else if (n_used < MAX_SLOTS) begin
                    id = n_used;
                    n_used++;
                end else begin
                    id = -1;
                end
                if (id < 0) begin
                    r.status = ST_FULL;
                end else begin
                    tbl_x[id] = px;
                    tbl_y[id] = py;
                    tbl_z[id] = pz;
                    tbl_active[id] = 1'b1;
                    r.status = ST_ADDED;
                    r.result_id = RES_ID_W'(id);
                end
            end
        end
        return r;
    endfunction

    // Draw a random request; some adds and most removes aim at live slots so overlaps and removes land.
    function automatic alloc_req_t make_request(int add_pct);
        alloc_req_t req;
        int live [$];
        int pick, w;
        req.func = FUNC_ADD;
        req.x = COORD_BITS'($urandom);
        req.y = COORD_BITS'($urandom);
        req.z = COORD_BITS'($urandom);
        req.id = RES_ID_W'($urandom);
        for (int i = 0; i < n_used; i++) begin
            if (tbl_active[i]) live.push_back(i);
        end
        if (int'($urandom_range(0, 99)) < add_pct) begin
            if (live.size() > 0 && $urandom_range(0, 99) < 35) begin
                pick = live[$urandom_range(0, live.size() - 1)];
                w = 2 * half_x;
                if (w > 8192) w = 8192;
                if ($urandom_range(0, 2) == 0) w = 0;
                req.x = COORD_BITS'(tbl_x[pick] + int'($urandom_range(0, 2 * w)) - w);
                w = 2 * half_y;
                if (w > 8192) w = 8192;
                req.y = COORD_BITS'(tbl_y[pick] + int'($urandom_range(0, 2 * w)) - w);
                req.z = COORD_BITS'(tbl_z[pick] + int'($urandom_range(0, 512)) - 256);
            end
        end else begin
            req.func = FUNC_REMOVE;
            if (live.size() > 0 && $urandom_range(0, 99) < 75) begin
                req.id = RES_ID_W'(live[$urandom_range(0, live.size() - 1)]);
            end
        end
        return req;
    endfunction

    // Count a mismatch; only the first ones are printed to keep the log short.
    task automatic report_mismatch(string msg);
        err_count++;
        if (err_count <= MAX_PRINTED) $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // Offer one request, wait until it is accepted, then record the expected response.
    task automatic send_request(alloc_req_t req, bit use_typed, alloc_resp_t typed_r);
        int gap;
        alloc_resp_t pred;
        gap = tx_idle_on ? int'($urandom_range(0, 10)) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_func    <= req.func;
        s_pos_x   <= req.x;
        s_pos_y   <= req.y;
        s_pos_z   <= req.z;
        s_slot_id <= req.id;
        do @(posedge aclk); while (!s_ready);
        pred = apply_request(req);
        expected_q.push_back(use_typed ? typed_r : pred);
    endtask

    // Write both half sizes on consecutive edges while the block is idle.
    task automatic write_half_sizes(int hx, int hy);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_HALF_X;
        cfg_wdata <= HALF_W'(hx);
        @(posedge aclk);
        cfg_addr  <= CFG_HALF_Y;
        cfg_wdata <= HALF_W'(hy);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        half_x = hx;
        half_y = hy;
    endtask

    // Stimulus: reset, directed rows, then random phases under several half sizes.
    initial begin : stimulus
        alloc_resp_t typed_r;
        int hx, hy;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_func    <= FUNC_ADD;
        s_pos_x   <= '0;
        s_pos_y   <= '0;
        s_pos_z   <= '0;
        s_slot_id <= '0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= CFG_HALF_X;
        cfg_wdata <= '0;
        clear_table();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        rst_done = 1'b1;
        @(posedge aclk);

        for (int k = 0; k < N_DIRECTED; k++) begin
            typed_r = DIR_ROWS[k].resp;
            send_request(DIR_ROWS[k].req, DIR_ROWS[k].typed, typed_r);
        end
        s_valid <= 1'b0;

        for (int p = 0; p < N_PHASES; p++) begin
            while (expected_q.size() != 0) @(posedge aclk);
            hx = (PHASE_HX[p] < 0) ? int'($urandom_range(0, 32767)) : PHASE_HX[p];
            hy = (PHASE_HY[p] < 0) ? int'($urandom_range(0, 32767)) : PHASE_HY[p];
            write_half_sizes(hx, hy);
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            // Hold the result side off while requests keep coming, so the input stalls.
            if (p == PRESSURE_PHASE) begin
                hold_off_req = 1'b1;
                tx_idle_on = 1'b0;
            end
            repeat (ITEMS_PER_PHASE) send_request(make_request(PHASE_ADD_PCT[p]), 1'b0, NO_RESP);
            s_valid <= 1'b0;
        end

        while (expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("overlap_checked_slot_allocator_core_tb passed");
        end else begin
            $display("overlap_checked_slot_allocator_core_tb failed");
        end
        $finish;
    end

    // Result side: random back-pressure, one long hold, and a field-by-field check.
    initial begin : result_sink
        alloc_resp_t exp_r;
        int stall;
        m_ready <= 1'b0;
        while (!rst_done) @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
            end else begin
                stall = rx_idle_on ? int'($urandom_range(0, 10)) : 0;
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result status %0d id %0d hit %0d",
                                          m_status, m_result_id, m_hit_id));
            end else begin
                exp_r = expected_q.pop_front();
                if (m_status !== exp_r.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              m_status, exp_r.status));
                if (m_result_id !== exp_r.result_id)
                    report_mismatch($sformatf("result_id %0d, expected %0d",
                                              m_result_id, exp_r.result_id));
                if (m_hit_id !== exp_r.hit_id)
                    report_mismatch($sformatf("hit_id %0d, expected %0d",
                                              m_hit_id, exp_r.hit_id));
            end
        end
    end

    // Watchdog: end the run when no transaction completes for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("overlap_checked_slot_allocator_core_tb failed");
            $finish;
        end
    end

endmodule

`default_nettype wire
